// File: hdl/triangle_plane_split_core_assert.svh
// Assertion macros for the triangle plane split core.
// Included by the top level only; the macros expect clk_i and rst_ni in scope.
`ifndef TRIANGLE_PLANE_SPLIT_CORE_ASSERT_SVH
`define TRIANGLE_PLANE_SPLIT_CORE_ASSERT_SVH
`define TPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("triangle_plane_split_core: same-cycle check failed");
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("triangle_plane_split_core: next-cycle check failed");
`endif

// File: hdl/tps_pkg.sv
// Shared constants, types and codes for the triangle plane split core.
// Used by every module of the block; depends on nothing.
package tps_pkg;

  localparam int CoordWidth  = 32;
  localparam int FracBits    = 16;
  localparam int TagWidth    = 32;
  localparam int TolWidth    = CoordWidth - 1;
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int ProdWidth   = DiffWidth + CoordWidth;
  localparam int SumWidth    = ProdWidth + 2;
  localparam int ShWidth     = SumWidth - FracBits;
  localparam int XProdWidth  = FracBits + CoordWidth + 1;
  localparam int DivCntWidth = $clog2(FracBits);
  localparam int PayloadBits = 9 * CoordWidth + TagWidth;
  localparam int DataWidth   = ((PayloadBits + 7) / 8) * 8;

  localparam int CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] RegPointX   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegPointY   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegPointZ   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegNormalX  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegNormalY  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegNormalZ  = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegTolerance = 3'd6;

  // Per-vertex classification.
  localparam logic [1:0] SdBack  = 2'd0;
  localparam logic [1:0] SdFront = 2'd1;
  localparam logic [1:0] SdOn    = 2'd2;

  // Side code of a result item.
  localparam logic [1:0] SideFront = 2'd0;
  localparam logic [1:0] SideBack  = 2'd1;
  localparam logic [1:0] SideOn    = 2'd2;

  localparam int FifoDepth    = 4;
  localparam int FifoPtrWidth = 2;
  localparam int FifoCntWidth = 3;

  typedef logic [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0]        point;
    coord_t [2:0]        normal;
    logic [TolWidth-1:0] tol;
  } cfg_t;

  typedef struct packed {
    coord_t [2:0][2:0]   v;
    coord_t [2:0]        d;
    logic [2:0][1:0]     sd;
    logic [TagWidth-1:0] tag;
  } tri_rec_t;

  typedef struct packed {
    logic                    full;
    logic                    empty;
    logic [FifoCntWidth-1:0] cnt;
  } fifo_stat_t;

endpackage

// File: hdl/triangle_plane_split_core.sv
// Triangle plane split core. An input item is one triangle (three signed
// fixed-point vertices and a face tag); the block classifies each vertex by its
// distance to the configured plane and emits one to three triangle items with a
// side code in tuser and tlast on the final piece. The front end takes one item
// a cycle while the queue is not full. A triangle that lies on one side goes
// straight to the piece output of the back end. A spanning triangle holds the
// back end through the three parallel restoring dividers, the crossing
// multiplication and the output of each piece; coordinates are Q16.16. A
// four-entry queue between the two ends absorbs bursts of spanning triangles.
// Depends on tps_pkg, tps_front, tps_fifo, tps_back and the assertion header.
`include "triangle_plane_split_core_assert.svh"

module triangle_plane_split_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tps_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [tps_pkg::CoordWidth-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // first_x, first_y, first_z, second_x .. third_z, face_tag, zero fill
  input  logic [tps_pkg::DataWidth-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out0_x, out0_y, out0_z, out1_x .. out2_z, face_tag_out, zero fill
  output logic [tps_pkg::DataWidth-1:0]     m_axis_tdata_o,
  // side
  output logic [1:0]                        m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);

  localparam int CW = tps_pkg::CoordWidth;

  tps_pkg::cfg_t              cfg_q;
  tps_pkg::coord_t [2:0][2:0] in_vtx, out_vtx;
  tps_pkg::tri_rec_t          rec, head;
  tps_pkg::fifo_stat_t        fifo_stat;
  logic                       rec_valid, fifo_push, fifo_pop;
  logic [tps_pkg::TagWidth-1:0] out_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tps_pkg::RegPointX:    cfg_q.point[0]  <= cfg_wdata_i;
        tps_pkg::RegPointY:    cfg_q.point[1]  <= cfg_wdata_i;
        tps_pkg::RegPointZ:    cfg_q.point[2]  <= cfg_wdata_i;
        tps_pkg::RegNormalX:   cfg_q.normal[0] <= cfg_wdata_i;
        tps_pkg::RegNormalY:   cfg_q.normal[1] <= cfg_wdata_i;
        tps_pkg::RegNormalZ:   cfg_q.normal[2] <= cfg_wdata_i;
        tps_pkg::RegTolerance: cfg_q.tol       <= cfg_wdata_i[tps_pkg::TolWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        in_vtx[i][k] = s_axis_tdata_i[(3*i+k)*CW +: CW];
      end
    end
  end

  tps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_vtx_i    (in_vtx),
    .in_tag_i    (s_axis_tdata_i[9*CW +: tps_pkg::TagWidth]),
    .rec_valid_o (rec_valid),
    .rec_ready_i (!fifo_stat.full),
    .rec_o       (rec)
  );

  assign fifo_push = rec_valid && !fifo_stat.full;

  tps_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .rec_i  (rec),
    .pop_i  (fifo_pop),
    .rec_o  (head),
    .stat_o (fifo_stat)
  );

  tps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!fifo_stat.empty),
    .head_i       (head),
    .pop_o        (fifo_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_vtx_o    (out_vtx),
    .out_tag_o    (out_tag),
    .out_side_o   (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        m_axis_tdata_o[(3*i+k)*CW +: CW] = out_vtx[i][k];
      end
    end
    m_axis_tdata_o[9*CW +: tps_pkg::TagWidth] = out_tag;
  end

  `TPS_ASSERT_IMPL(a_fifo_bound, 1'b1, fifo_stat.cnt <= tps_pkg::FifoCntWidth'(tps_pkg::FifoDepth))
  `TPS_ASSERT_NEXT(a_fifo_fill, fifo_push && !fifo_pop, fifo_stat.cnt == $past(fifo_stat.cnt) + 1'b1)
  `TPS_ASSERT_NEXT(a_fifo_drain, fifo_pop && !fifo_push, fifo_stat.cnt == $past(fifo_stat.cnt) - 1'b1)

endmodule

// File: hdl/tps_front.sv
// Front end: plane distance of each vertex and its classification.
// Two register stages; depends on tps_pkg.
module tps_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tps_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tps_pkg::coord_t [2:0][2:0]    in_vtx_i,
  input  logic [tps_pkg::TagWidth-1:0]  in_tag_i,
  output logic                          rec_valid_o,
  input  logic                          rec_ready_i,
  output tps_pkg::tri_rec_t             rec_o
);

  logic                                   s1_valid_q, s2_valid_q;
  logic                                   en1, en2;
  logic signed [tps_pkg::DiffWidth-1:0]   diff_q [3][3];
  logic signed [tps_pkg::ProdWidth-1:0]   prod_q [3][3];
  tps_pkg::coord_t [2:0][2:0]             v1_q, v2_q;
  logic [tps_pkg::TagWidth-1:0]           tag1_q, tag2_q;

  assign en2        = !s2_valid_q || rec_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign rec_valid_o = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      v1_q   <= in_vtx_i;
      tag1_q <= in_tag_i;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          diff_q[i][k] <= $signed({in_vtx_i[i][k][tps_pkg::CoordWidth-1], in_vtx_i[i][k]})
                        - $signed({cfg_i.point[k][tps_pkg::CoordWidth-1], cfg_i.point[k]});
        end
      end
    end
    if (en2 && s1_valid_q) begin
      v2_q   <= v1_q;
      tag2_q <= tag1_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= diff_q[i][k] * $signed(cfg_i.normal[k]);
        end
      end
    end
  end

  always_comb begin
    logic signed [tps_pkg::SumWidth-1:0] sum;
    logic signed [tps_pkg::ShWidth-1:0]  sh;
    logic [tps_pkg::ShWidth-tps_pkg::CoordWidth:0] hi;
    logic signed [tps_pkg::CoordWidth:0] dx, tolx;
    tps_pkg::coord_t dd;
    rec_o.v   = v2_q;
    rec_o.tag = tag2_q;
    rec_o.d   = '0;
    rec_o.sd  = '0;
    tolx = $signed({2'b00, cfg_i.tol});
    for (int i = 0; i < 3; i++) begin
      sum = tps_pkg::SumWidth'(prod_q[i][0]) + tps_pkg::SumWidth'(prod_q[i][1])
          + tps_pkg::SumWidth'(prod_q[i][2]);
      sh  = tps_pkg::ShWidth'(sum >>> tps_pkg::FracBits);
      hi  = sh[tps_pkg::ShWidth-1:tps_pkg::CoordWidth-1];
      if ((&hi) || !(|hi)) begin
        dd = sh[tps_pkg::CoordWidth-1:0];
      end else if (sh[tps_pkg::ShWidth-1]) begin
        dd = {1'b1, {(tps_pkg::CoordWidth-1){1'b0}}};
      end else begin
        dd = {1'b0, {(tps_pkg::CoordWidth-1){1'b1}}};
      end
      rec_o.d[i] = dd;
      dx = $signed({dd[tps_pkg::CoordWidth-1], dd});
      if (dx > tolx) begin
        rec_o.sd[i] = tps_pkg::SdFront;
      end else if (dx < -tolx) begin
        rec_o.sd[i] = tps_pkg::SdBack;
      end else begin
        rec_o.sd[i] = tps_pkg::SdOn;
      end
    end
  end

endmodule

// File: hdl/tps_fifo.sv
// Short queue of classified triangles between the front and back ends.
// Register array with a combinational head; depends on tps_pkg.
module tps_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tps_pkg::tri_rec_t   rec_i,
  input  logic                pop_i,
  output tps_pkg::tri_rec_t   rec_o,
  output tps_pkg::fifo_stat_t stat_o
);

  tps_pkg::tri_rec_t                   mem_q [tps_pkg::FifoDepth];
  logic [tps_pkg::FifoPtrWidth-1:0]    wr_q, rd_q;
  logic [tps_pkg::FifoCntWidth-1:0]    cnt_q;

  assign rec_o        = mem_q[rd_q];
  assign stat_o.cnt   = cnt_q;
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == tps_pkg::FifoCntWidth'(tps_pkg::FifoDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

endmodule

// File: hdl/tps_back.sv
// Back end: crossing points of spanning triangles and piece output.
// Three serial dividers, three crossing multipliers and an output register; uses tps_pkg.
module tps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  tps_pkg::tri_rec_t             head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tps_pkg::coord_t [2:0][2:0]    out_vtx_o,
  output logic [tps_pkg::TagWidth-1:0]  out_tag_o,
  output logic [1:0]                    out_side_o,
  output logic                          out_last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StMul  = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;
  localparam int CW = tps_pkg::CoordWidth;
  localparam int FB = tps_pkg::FracBits;

  typedef struct packed {
    tps_pkg::coord_t [2:0][2:0] v;
    logic [1:0]                 side;
  } piece_t;

  logic [1:0]                         state_q;
  logic [1:0]                         idx_q;
  tps_pkg::tri_rec_t                  cur_q;
  logic [CW+1:0]                      rem_q [3];
  logic [CW:0]                        den_q [3];
  logic [FB-1:0]                      quo_q [3];
  logic [tps_pkg::DivCntWidth-1:0]    cnt_q;
  logic [1:0]                         ec_q, pe_q;
  logic                               pv_q;
  logic [tps_pkg::XProdWidth-1:0]     prod_q [3];
  logic [2:0]                         esgn_q;
  tps_pkg::coord_t [2:0][2:0]         xp_q;
  logic                               out_valid_q;

  piece_t                             pc [3];
  logic [1:0]                         np;
  logic                               head_spans;
  logic                               out_load, emit_fire, last_piece;
  logic [CW-1:0]                      amag [3];
  logic [CW:0]                        bsum [3];
  logic [FB-1:0]                      t_sel;
  logic [tps_pkg::XProdWidth-1:0]     prod_d [3];
  logic [2:0]                         esgn_d;
  tps_pkg::coord_t [2:0]              xp_d;

  function automatic logic [CW-1:0] dmag(tps_pkg::coord_t d);
    return d[CW-1] ? (~d + 1'b1) : d;
  endfunction

  assign head_spans = ((head_i.sd[0] == tps_pkg::SdFront) || (head_i.sd[1] == tps_pkg::SdFront)
                    || (head_i.sd[2] == tps_pkg::SdFront))
                   && ((head_i.sd[0] == tps_pkg::SdBack) || (head_i.sd[1] == tps_pkg::SdBack)
                    || (head_i.sd[2] == tps_pkg::SdBack));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amag[i] = dmag(head_i.d[i]);
      bsum[i] = {1'b0, amag[i]} + {1'b0, dmag(head_i.d[(i == 2) ? 0 : i + 1])};
    end
  end

  // Crossing multiplier inputs for the edge selected by ec_q, and the crossing point of edge pe_q.
  always_comb begin
    logic [1:0]    ei, ej;
    logic [CW:0]   e, emag;
    tps_pkg::coord_t vi, vj, vb;
    logic [CW:0]   q;
    logic [CW+1:0] res;
    case (ec_q)
      2'd1:    begin t_sel = quo_q[1]; ei = 2'd1; ej = 2'd2; end
      2'd2:    begin t_sel = quo_q[2]; ei = 2'd2; ej = 2'd0; end
      default: begin t_sel = quo_q[0]; ei = 2'd0; ej = 2'd1; end
    endcase
    for (int k = 0; k < 3; k++) begin
      vi = cur_q.v[ei][k];
      vj = cur_q.v[ej][k];
      e  = {vj[CW-1], vj} - {vi[CW-1], vi};
      emag = e[CW] ? (~e + 1'b1) : e;
      esgn_d[k] = e[CW];
      prod_d[k] = tps_pkg::XProdWidth'(t_sel) * tps_pkg::XProdWidth'(emag);
      vb  = cur_q.v[pe_q][k];
      q   = prod_q[k][FB +: CW+1];
      res = esgn_q[k] ? ({vb[CW-1], vb[CW-1], vb} - {1'b0, q})
                      : ({vb[CW-1], vb[CW-1], vb} + {1'b0, q});
      xp_d[k] = res[CW-1:0];
    end
  end

  // Front and back vertex lists, then the pieces of the current triangle.
  always_comb begin
    tps_pkg::coord_t [3:0][2:0] fv, bv;
    logic [2:0] nf, nb;
    logic [1:0] n;
    logic       pos, neg, cr;
    int         j;
    fv = '0;
    bv = '0;
    nf = '0;
    nb = '0;
    n  = '0;
    pos = 1'b0;
    neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos = pos | (cur_q.sd[i] == tps_pkg::SdFront);
      neg = neg | (cur_q.sd[i] == tps_pkg::SdBack);
    end
    for (int i = 0; i < 3; i++) begin
      pc[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      j  = (i == 2) ? 0 : i + 1;
      cr = ((cur_q.sd[i] == tps_pkg::SdFront) && (cur_q.sd[j] == tps_pkg::SdBack))
        || ((cur_q.sd[i] == tps_pkg::SdBack) && (cur_q.sd[j] == tps_pkg::SdFront));
      if (cur_q.sd[i] != tps_pkg::SdBack && nf < 3'd4) begin
        fv[nf[1:0]] = cur_q.v[i];
        nf = nf + 1'b1;
      end
      if (cur_q.sd[i] != tps_pkg::SdFront && nb < 3'd4) begin
        bv[nb[1:0]] = cur_q.v[i];
        nb = nb + 1'b1;
      end
      if (cr) begin
        if (nf < 3'd4) begin
          fv[nf[1:0]] = xp_q[i];
          nf = nf + 1'b1;
        end
        if (nb < 3'd4) begin
          bv[nb[1:0]] = xp_q[i];
          nb = nb + 1'b1;
        end
      end
    end
    if (!(pos && neg)) begin
      pc[0].v    = cur_q.v;
      pc[0].side = pos ? tps_pkg::SideFront : (neg ? tps_pkg::SideBack : tps_pkg::SideOn);
      np = 2'd1;
    end else begin
      if (nf >= 3'd3) begin
        pc[n].v    = {fv[2], fv[1], fv[0]};
        pc[n].side = tps_pkg::SideFront;
        n = n + 1'b1;
        if (nf == 3'd4) begin
          pc[n].v    = {fv[3], fv[2], fv[0]};
          pc[n].side = tps_pkg::SideFront;
          n = n + 1'b1;
        end
      end
      if (nb >= 3'd3 && n < 2'd3) begin
        pc[n].v    = {bv[2], bv[1], bv[0]};
        pc[n].side = tps_pkg::SideBack;
        n = n + 1'b1;
        if (nb == 3'd4 && n < 2'd3) begin
          pc[n].v    = {bv[3], bv[2], bv[0]};
          pc[n].side = tps_pkg::SideBack;
          n = n + 1'b1;
        end
      end
      np = n;
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign emit_fire  = (state_q == StEmit) && out_load;
  assign last_piece = (idx_q == np - 2'd1);
  assign pop_o      = head_valid_i && ((state_q == StIdle) || (emit_fire && last_piece));
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= '0;
      ec_q        <= '0;
      pe_q        <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        idx_q   <= '0;
        cnt_q   <= '0;
        state_q <= head_spans ? StDiv : StEmit;
      end else begin
        case (state_q)
          StDiv: begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == tps_pkg::DivCntWidth'(FB - 1)) begin
              state_q <= StMul;
              ec_q    <= '0;
              pv_q    <= 1'b0;
            end
          end
          StMul: begin
            pv_q <= (ec_q != 2'd3);
            if (ec_q != 2'd3) begin
              ec_q <= ec_q + 1'b1;
              pe_q <= ec_q;
            end
            if (pv_q && pe_q == 2'd2) begin
              state_q <= StEmit;
              idx_q   <= '0;
            end
          end
          StEmit: begin
            if (emit_fire) begin
              if (last_piece) begin
                state_q <= StIdle;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= {2'b00, amag[i]};
        den_q[i] <= bsum[i];
        quo_q[i] <= '0;
      end
    end else if (state_q == StDiv) begin
      for (int i = 0; i < 3; i++) begin
        if ({rem_q[i][CW:0], 1'b0} >= {1'b0, den_q[i]}) begin
          rem_q[i] <= {rem_q[i][CW:0], 1'b0} - {1'b0, den_q[i]};
          quo_q[i] <= {quo_q[i][FB-2:0], 1'b1};
        end else begin
          rem_q[i] <= {rem_q[i][CW:0], 1'b0};
          quo_q[i] <= {quo_q[i][FB-2:0], 1'b0};
        end
      end
    end
    if (state_q == StMul) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= prod_d[k];
      end
      esgn_q <= esgn_d;
      if (pv_q) xp_q[pe_q] <= xp_d;
    end
    if (emit_fire) begin
      out_vtx_o  <= pc[idx_q].v;
      out_side_o <= pc[idx_q].side;
      out_tag_o  <= cur_q.tag;
      out_last_o <= last_piece;
    end
  end

endmodule
